// ===== rtl/hnsr_pkg.sv =====
// Package with the sizes, operation codes and widths of the Hopfield store and recall unit.
`default_nettype none
package hnsr_pkg;

	// Grid side; the network holds SIDE*SIDE nodes.
	localparam int SIDE = 8;
	localparam int NODES = SIDE * SIDE;
	localparam int NODE_W = $clog2(NODES);

	// The weight memory is addressed by {row, column}, each NODE_W bits.
	localparam int MEM_AW = 2 * NODE_W;
	localparam int MEM_DEPTH = 1 << MEM_AW;

	localparam int WEIGHT_W = 8;
	localparam logic signed [WEIGHT_W-1:0] WEIGHT_MAX = 8'sd127;
	localparam logic signed [WEIGHT_W-1:0] WEIGHT_MIN = -8'sd127;

	// Width of one signed weight times a sign.
	localparam int TERM_W = WEIGHT_W + 1;

	// Row sum over NODES-1 weights of magnitude at most 127, plus a sign bit.
	localparam int SUM_W = $clog2((NODES - 1) * 127 + 1) + 1;

	// Firing threshold register.
	localparam int THR_W = 14;
	localparam int CMP_W = (SUM_W > THR_W) ? SUM_W : THR_W;

	// Input field widths.
	localparam int OP_W = 2;
	localparam int IDX_W = 6;

	// APB side.
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	// Operation codes.
	localparam logic [OP_W-1:0] OP_WRITE  = 2'd0;
	localparam logic [OP_W-1:0] OP_READ   = 2'd1;
	localparam logic [OP_W-1:0] OP_LEARN  = 2'd2;
	localparam logic [OP_W-1:0] OP_RECALL = 2'd3;

	// Register index of the firing threshold.
	localparam logic [PADDR_W-3:0] REG_THRESHOLD = 1'b0;

endpackage
`default_nettype wire

// ===== rtl/hopfield_network_store_recall_unit.sv =====
// Top level of the Hopfield store and recall unit: sequencer, weight memory and shared MAC.
//
// Usage. Commands arrive on the input channel (in_valid/in_ready) as an operation code,
// a node index and a node value. Every command produces exactly one result transfer on
// the output channel (out_valid/out_ready): the addressed node bit for a read, zero
// otherwise, together with the operation code that finished.
// Write and read take effect at the input transfer and their result is shown in the
// following cycle. Learn and recall walk every weight of the NODES x NODES matrix, one
// weight per cycle through the single read port of the weight memory, and post their
// result from the drain state that follows the last weight read.
// The block works on one command at a time; in_ready is low while a learn or recall is
// running or while a finished result still waits in the output register with out_ready
// low. A stalled receiver therefore holds the result and blocks new commands.
// After reset the node states are cleared at once, and a clearing pass zeroes all
// MEM_DEPTH weight memory entries (4096 by default), one entry per cycle; no command
// is taken during that pass. The threshold register on the APB port is taken at any
// time, but should only be written while the block is idle.
`default_nettype none
module hopfield_network_store_recall_unit (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// Command channel
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic [hnsr_pkg::OP_W-1:0]      operation,
	input  wire logic [hnsr_pkg::IDX_W-1:0]     node_index,
	input  wire logic                           node_value,
	// Result channel
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic                                node_bit,
	output logic [hnsr_pkg::OP_W-1:0]           finished_operation,
	// Configuration port
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [hnsr_pkg::PADDR_W-1:0]   paddr,
	input  wire logic [hnsr_pkg::PDATA_W-1:0]   pwdata,
	output logic [hnsr_pkg::PDATA_W-1:0]        prdata,
	output logic                                pready
);
	import hnsr_pkg::*;

	// Sequencer states.
	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_RUN   = 2'd2;
	localparam logic [1:0] ST_DRAIN = 2'd3;

	logic [1:0]                 state_q;
	logic [OP_W-1:0]            op_q;
	logic [NODE_W-1:0]          row_q;
	logic [NODE_W-1:0]          col_q;
	logic [NODES-1:0]           nodes_q;
	logic signed [THR_W-1:0]    thr_q;

	// Memory read stage.
	logic                       valid_s1;
	logic [NODE_W-1:0]          row_s1;
	logic [NODE_W-1:0]          col_s1;
	logic signed [WEIGHT_W-1:0] weight_s1;

	logic signed [SUM_W-1:0]    acc_q;

	logic                       out_valid_q;
	logic                       node_bit_q;
	logic [OP_W-1:0]            fin_op_q;

	// The weight memory: one write port, one registered read port.
	logic signed [WEIGHT_W-1:0] wmem [MEM_DEPTH];
	logic                       mem_we;
	logic [MEM_AW-1:0]          mem_waddr;
	logic signed [WEIGHT_W-1:0] mem_wdata;

	logic                       in_xfer;
	logic                       out_free;
	logic                       post_result;
	logic                       idx_ok;
	logic [NODE_W-1:0]          idx;
	logic                       last_col;
	logic                       last_row;
	logic                       sweep_end;
	logic                       clear_end;
	logic                       cfg_write;
	logic                       thr_hit;

	// Learn and recall datapath.
	logic                       diag_s1;
	logic                       same_s1;
	logic signed [WEIGHT_W-1:0] learned_s1;
	logic signed [TERM_W-1:0]   term_s1;
	logic signed [SUM_W-1:0]    row_sum_s1;
	logic                       fire_s1;

	// ---------------------------------------------------------------------------------
	// Handshakes and command decode
	// ---------------------------------------------------------------------------------
	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == ST_IDLE) && out_free;
	assign in_xfer  = in_valid && in_ready;

	// A result is posted right after a write or read transfer, or when a sweep drains.
	assign post_result = (in_xfer && (operation == OP_WRITE || operation == OP_READ)) ||
		(state_q == ST_DRAIN);

	assign out_valid          = out_valid_q;
	assign node_bit           = node_bit_q;
	assign finished_operation = fin_op_q;

	// Indexes beyond the network are ignored by write and read as zero.
	assign idx    = NODE_W'(node_index);
	assign idx_ok = 32'(node_index) < 32'(NODES);

	assign last_col  = col_q == NODE_W'(NODES - 1);
	assign last_row  = row_q == NODE_W'(NODES - 1);
	assign sweep_end = last_col && last_row;
	assign clear_end = &{row_q, col_q};

	// ---------------------------------------------------------------------------------
	// Configuration port
	// ---------------------------------------------------------------------------------
	assign pready    = 1'b1;
	assign thr_hit   = paddr[PADDR_W-1:2] == REG_THRESHOLD;
	assign cfg_write = psel && penable && pwrite && pready && thr_hit;
	assign prdata    = thr_hit ? PDATA_W'(thr_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= '0;
		end else if (cfg_write) begin
			thr_q <= signed'(pwdata[THR_W-1:0]);
		end
	end

	// ---------------------------------------------------------------------------------
	// Weight update and row accumulation on the word read in the previous cycle
	// ---------------------------------------------------------------------------------
	assign diag_s1 = row_s1 == col_s1;
	assign same_s1 = nodes_q[row_s1] == nodes_q[col_s1];

	// Hebbian step with saturation at +/-127; the diagonal stays unchanged (zero).
	always_comb begin
		if (diag_s1) begin
			learned_s1 = weight_s1;
		end else if (same_s1) begin
			learned_s1 = (weight_s1 == WEIGHT_MAX) ? WEIGHT_MAX : weight_s1 + 8'sd1;
		end else begin
			learned_s1 = (weight_s1 == WEIGHT_MIN) ? WEIGHT_MIN : weight_s1 - 8'sd1;
		end
	end

	// Signed contribution of node col_s1 to the sum of node row_s1.
	always_comb begin
		if (diag_s1) begin
			term_s1 = '0;
		end else if (nodes_q[col_s1]) begin
			term_s1 = TERM_W'(weight_s1);
		end else begin
			term_s1 = -TERM_W'(weight_s1);
		end
	end

	// The first column of a row starts a fresh sum.
	assign row_sum_s1 = ((col_s1 == '0) ? '0 : acc_q) + SUM_W'(term_s1);
	assign fire_s1    = CMP_W'(row_sum_s1) >= CMP_W'(thr_q);

	// ---------------------------------------------------------------------------------
	// Weight memory
	// ---------------------------------------------------------------------------------
	always_comb begin
		if (state_q == ST_CLEAR) begin
			mem_we    = 1'b1;
			mem_waddr = {row_q, col_q};
			mem_wdata = '0;
		end else begin
			mem_we    = valid_s1 && (op_q == OP_LEARN);
			mem_waddr = {row_s1, col_s1};
			mem_wdata = learned_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			wmem[mem_waddr] <= mem_wdata;
		end
		weight_s1 <= wmem[{row_q, col_q}];
	end

	// ---------------------------------------------------------------------------------
	// Sequencer, node states and result register
	// ---------------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			op_q        <= OP_WRITE;
			row_q       <= '0;
			col_q       <= '0;
			nodes_q     <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// One weight read per cycle while a sweep runs.
			valid_s1 <= (state_q == ST_RUN);
			if (post_result) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_CLEAR: begin
					{row_q, col_q} <= {row_q, col_q} + 1'b1;
					if (clear_end) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_xfer) begin
						op_q  <= operation;
						row_q <= '0;
						col_q <= '0;
						if (operation == OP_WRITE || operation == OP_READ) begin
							if (operation == OP_WRITE && idx_ok) begin
								nodes_q[idx] <= node_value;
							end
						end else begin
							state_q <= ST_RUN;
						end
					end
				end
				ST_RUN: begin
					// Weights are read row by row.
					if (last_col) begin
						col_q <= '0;
						row_q <= row_q + 1'b1;
					end else begin
						col_q <= col_q + 1'b1;
					end
					if (sweep_end) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					// The last weight is processed here; the result is posted.
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			// A recall updates node row_s1 once its whole row has been summed.
			if (valid_s1 && op_q == OP_RECALL && col_s1 == NODE_W'(NODES - 1)) begin
				nodes_q[row_s1] <= fire_s1;
			end
		end
	end

	// Read-stage tags and the running sum need no reset.
	always_ff @(posedge clk) begin
		row_s1 <= row_q;
		col_s1 <= col_q;
		if (valid_s1) begin
			acc_q <= row_sum_s1;
		end
		if (in_xfer) begin
			node_bit_q <= (operation == OP_READ) && idx_ok && nodes_q[idx];
			fin_op_q   <= operation;
		end else if (state_q == ST_DRAIN) begin
			node_bit_q <= 1'b0;
		end
	end

endmodule
`default_nettype wire
